>>> design/skc_pkg.sv
package skc_pkg;

  // Frame format
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int MAG_W       = SAMPLE_BITS;

  // Shared multiplier widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Knee divider numerator width
  localparam int DIVN_W = 26;

  // Fixed-point constants
  localparam logic [15:0] DB_FLOOR_Q8       = 16'd25600;
  localparam logic [14:0] TARGET_MAX_Q8     = 15'd32767;
  localparam logic [32:0] THREE_DB_Q24      = 33'd50331648;
  localparam logic [31:0] DB_PER_OCTAVE_Q16 = 32'd394566;
  localparam logic [31:0] OCTAVE_PER_DB_Q32 = 32'd713378626;
  localparam logic [31:0] LN2_Q32           = 32'd2977044472;
  localparam logic [24:0] ONE_Q24           = 25'd16777216;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_THRESHOLD    = 3'd0,
    REG_KNEE_WIDTH   = 3'd1,
    REG_SLOPE        = 3'd2,
    REG_MAKEUP       = 3'd3,
    REG_ATTACK       = 3'd4,
    REG_RELEASE      = 3'd5,
    REG_SLOW_RELEASE = 3'd6,
    REG_BYPASS       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] threshold_db;
    logic [12:0] knee_width_db;
    logic [15:0] slope;
    logic [23:0] makeup_gain;
    logic [23:0] attack_coef;
    logic [23:0] release_coef;
    logic [23:0] slow_release_coef;
    logic        bypass;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] out_ch0;
    logic [SAMPLE_BITS-1:0] out_ch1;
    logic [14:0]            gain_reduction;
    logic [14:0]            block_max_reduction;
    logic                   block_done;
  } res_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_SQ, S_SQW, S_LOG, S_LOGW, S_GC, S_GCW,
    S_KN1, S_KN2, S_KN3, S_DIV, S_ENV, S_ENV1, S_ENV2,
    S_EXP, S_EXPW, S_Y, S_YW, S_T, S_TW, S_D, S_DW,
    S_SH, S_GM, S_GMW, S_C0, S_C0W, S_C1, S_C1W, S_FIN
  } state_t;

  // Saturate a 17-bit reduction to Q7.8 range
  function automatic logic [14:0] sat15(input logic [16:0] v);
    sat15 = (v > 17'(TARGET_MAX_Q8)) ? TARGET_MAX_Q8 : v[14:0];
  endfunction

  // Round a Q8.24 dB value to Q7.8 and saturate
  function automatic logic [14:0] q24_to_q8(input logic [31:0] v);
    logic [32:0] s;
    s = 33'(v) + 33'd32768;
    q24_to_q8 = sat15(s[32:16]);
  endfunction

  // floor(2^32 / k) for the Taylor term divisors
  function automatic logic [31:0] recip_k(input logic [4:0] k);
    case (k)
      5'd2:    recip_k = 32'd2147483648;
      5'd3:    recip_k = 32'd1431655765;
      5'd4:    recip_k = 32'd1073741824;
      5'd5:    recip_k = 32'd858993459;
      5'd6:    recip_k = 32'd715827882;
      5'd7:    recip_k = 32'd613566756;
      5'd8:    recip_k = 32'd536870912;
      5'd9:    recip_k = 32'd477218588;
      5'd10:   recip_k = 32'd429496729;
      5'd11:   recip_k = 32'd390451572;
      5'd12:   recip_k = 32'd357913941;
      5'd13:   recip_k = 32'd330382099;
      5'd14:   recip_k = 32'd306783378;
      5'd15:   recip_k = 32'd286331153;
      5'd16:   recip_k = 32'd268435456;
      default: recip_k = 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

>>> design/soft_knee_peak_compressor.sv
// A bypassed frame goes straight to the result; a compressed frame runs the
// whole sequence, shorter below the threshold, longer inside the soft knee,
// and shorter again for a silent frame, which skips the log detector.
// Frames are taken one at a time, the next input on the same edge as the
// earliest output when the output does not stall; the gain series on the
// shared multiplier and the 26-step knee divider take most of the sequence.
// Reset (rst, synchronous): envelope and block maximum cleared to 0 dB,
// registers to defaults with unity makeup gain, no result pending.
module soft_knee_peak_compressor (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_index,
  input  logic [23:0]                            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [skc_pkg::SAMPLE_BITS-1:0] sample_ch0,
  input  logic signed [skc_pkg::SAMPLE_BITS-1:0] sample_ch1,
  input  logic                                   end_of_block,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [skc_pkg::SAMPLE_BITS-1:0] out_ch0,
  output logic signed [skc_pkg::SAMPLE_BITS-1:0] out_ch1,
  output logic [14:0]                            gain_reduction,
  output logic [14:0]                            block_max_reduction,
  output logic                                   block_done
);
  import skc_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid, res_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{threshold_db: '0, knee_width_db: '0, slope: '0, makeup_gain: 24'd65536,
               attack_coef: '0, release_coef: '0, slow_release_coef: '0, bypass: 1'b0};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD:    cfg.threshold_db      <= cfg_data[14:0];
        REG_KNEE_WIDTH:   cfg.knee_width_db     <= cfg_data[12:0];
        REG_SLOPE:        cfg.slope             <= cfg_data[15:0];
        REG_MAKEUP:       cfg.makeup_gain       <= cfg_data;
        REG_ATTACK:       cfg.attack_coef       <= cfg_data;
        REG_RELEASE:      cfg.release_coef      <= cfg_data;
        REG_SLOW_RELEASE: cfg.slow_release_coef <= cfg_data;
        REG_BYPASS:       cfg.bypass            <= cfg_data[0];
        default:          cfg.bypass            <= cfg.bypass;
      endcase
    end
  end

  skc_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_ch0   (sample_ch0),
    .sample_ch1   (sample_ch1),
    .end_of_block (end_of_block),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Output register: take a new result once the old one has gone
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_ch0             <= res.out_ch0;
      out_ch1             <= res.out_ch1;
      gain_reduction      <= res.gain_reduction;
      block_max_reduction <= res.block_max_reduction;
      block_done          <= res.block_done;
    end
  end

endmodule

>>> design/skc_mul.sv
module skc_mul (
  input  logic                        clk,
  input  logic [skc_pkg::MUL_A_W-1:0] a,
  input  logic [skc_pkg::MUL_B_W-1:0] b,
  output logic [skc_pkg::MUL_P_W-1:0] p
);
  import skc_pkg::*;

  // Registered product
  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

>>> design/skc_seq.sv
module skc_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  skc_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [skc_pkg::SAMPLE_BITS-1:0] sample_ch0,
  input  logic [skc_pkg::SAMPLE_BITS-1:0] sample_ch1,
  input  logic                            end_of_block,
  output logic                            res_valid,
  input  logic                            res_ready,
  output skc_pkg::res_t                   res
);
  import skc_pkg::*;

  localparam int SB = SAMPLE_BITS;

  state_t state, state_next;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] p;

  // Frame registers
  logic [SB-1:0]    s0, s1;
  logic [MAG_W-1:0] mag0, mag1, peak;
  logic             eob;

  // Detector
  logic [4:0]  cnt;
  logic [30:0] xn;
  logic [15:0] frac;
  logic [4:0]  e;
  logic [15:0] xdb;

  // Gain computer and divider
  logic [14:0]       g;
  logic [55:0]       acc;
  logic [DIVN_W-1:0] divn;
  logic [12:0]       rem;

  // Envelope and gain
  logic [23:0] coef;
  logic [31:0] env, run_max;
  logic [14:0] gr;
  logic [5:0]  nexp;
  logic [23:0] f;
  logic [31:0] y;
  logic [32:0] term;
  logic [31:0] vdiv;
  logic [34:0] sum;
  logic [32:0] gain;
  logic [31:0] gm;
  logic [SB-1:0] o0, o1;

  skc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  // Input magnitudes and peak
  logic [MAG_W-1:0] in_mag0, in_mag1;
  logic [SB-1:0]    in_s1;
  assign in_s1   = (CHANNELS >= 2) ? sample_ch1 : '0;
  assign in_mag0 = sample_ch0[SB-1] ? MAG_W'(-sample_ch0) : MAG_W'(sample_ch0);
  assign in_mag1 = in_s1[SB-1] ? MAG_W'(-in_s1) : MAG_W'(in_s1);

  // Leading-zero count of the peak
  function automatic logic [4:0] lead_zeros(input logic [MAG_W-1:0] v);
    logic [4:0] lz;
    lz = 5'(MAG_W - 1);
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) lz = 5'(MAG_W - 1 - i);
    end
    return lz;
  endfunction

  logic [4:0]       lz;
  logic [MAG_W+30:0] nshift;
  assign lz     = lead_zeros(peak);
  assign nshift = {peak, 31'd0} << lz;

  // Squaring step
  logic [31:0] sq_x;
  assign sq_x = p[61:30];

  // Log magnitude to dB
  logic [20:0] lg, top_lg, neg_lg;
  logic [40:0] db_sum;
  logic [16:0] db_mag;
  assign lg     = {e, frac};
  assign top_lg = 21'(SB - 1) << 16;
  assign neg_lg = (top_lg > lg) ? (top_lg - lg) : '0;
  assign db_sum = 41'(p[39:0]) + 41'd8388608;
  assign db_mag = (db_sum[40:24] > 17'(DB_FLOOR_Q8)) ? 17'(DB_FLOOR_Q8) : db_sum[40:24];

  // Knee region compare
  logic signed [17:0] t18, w18, x2, x18, lo, hi, dv, d2;
  logic below, above;
  assign t18   = $signed({{3{cfg.threshold_db[14]}}, cfg.threshold_db});
  assign w18   = $signed({5'd0, cfg.knee_width_db});
  assign x18   = $signed({{2{xdb[15]}}, xdb});
  assign x2    = $signed({xdb[15], xdb, 1'b0});
  assign lo    = (t18 <<< 1) - w18;
  assign hi    = (t18 <<< 1) + w18;
  assign dv    = x18 - t18;
  assign d2    = x2 - lo;
  assign below = (x2 <= lo);
  assign above = (x2 > hi);

  logic [33:0] hi_sum;
  logic [45:0] kn_num;
  assign hi_sum = 34'(p[32:0]) + 34'd32768;
  assign kn_num = 46'(p[43:0]) + (46'(cfg.knee_width_db) << 18);

  // Restoring divide step
  logic [13:0] trial;
  logic        ge;
  logic [DIVN_W-1:0] quo;
  assign trial = {rem, divn[DIVN_W-1]};
  assign ge    = (trial >= 14'(cfg.knee_width_db));
  assign quo   = {divn[DIVN_W-2:0], ge};

  // Envelope coefficient select
  logic [31:0] tgt;
  logic [23:0] coef_sel;
  logic [57:0] env_sum;
  logic [31:0] env_new;
  assign tgt = {1'b0, g, 16'd0};
  always_comb begin
    if (tgt > env) coef_sel = cfg.attack_coef;
    else if ({1'b0, env} > (33'(tgt) + THREE_DB_Q24)) coef_sel = cfg.release_coef;
    else coef_sel = cfg.slow_release_coef;
  end
  assign env_sum = 58'(acc) + 58'(p[56:0]) + 58'd8388608;
  assign env_new = env_sum[55:24];

  // Taylor term divide correction
  logic [31:0] q0, qf;
  logic [36:0] prodk, rk;
  assign q0    = p[63:32];
  assign prodk = 37'(q0) * 37'(cnt);
  assign rk    = 37'(vdiv) - prodk;
  assign qf    = (rk >= 37'(cnt)) ? (q0 + 32'd1) : q0;

  // Makeup product
  logic [57:0] gm_sum;
  assign gm_sum = 58'(p[56:0]) + 58'd8388608;

  // Scale a magnitude, round and saturate with sign
  function automatic logic [SB-1:0] sat_scale(input logic [MUL_P_W-1:0] pr,
                                              input logic neg);
    logic [MUL_P_W:0]    sv;
    logic [MUL_P_W-24:0] mm;
    logic [MUL_P_W-24:0] lim;
    sv  = (MUL_P_W+1)'(pr) + (MUL_P_W+1)'(24'd8388608);
    mm  = sv[MUL_P_W:24];
    lim = neg ? ((MUL_P_W-23)'(1) << (SB - 1)) : (((MUL_P_W-23)'(1) << (SB - 1)) - 1'b1);
    if (mm > lim) mm = lim;
    return neg ? SB'((MUL_P_W-23)'(0) - mm) : SB'(mm);
  endfunction

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = cfg.bypass ? S_FIN : S_NORM;
      S_NORM: state_next = (peak == '0) ? S_GC : S_SQ;
      S_SQ:   state_next = S_SQW;
      S_SQW:  state_next = (cnt == 5'd15) ? S_LOG : S_SQ;
      S_LOG:  state_next = S_LOGW;
      S_LOGW: state_next = S_GC;
      S_GC: begin
        if (below) state_next = S_ENV;
        else if (above) state_next = S_GCW;
        else state_next = S_KN1;
      end
      S_GCW:  state_next = S_ENV;
      S_KN1:  state_next = S_KN2;
      S_KN2:  state_next = S_KN3;
      S_KN3:  state_next = S_DIV;
      S_DIV:  state_next = (cnt == 5'(DIVN_W - 1)) ? S_ENV : S_DIV;
      S_ENV:  state_next = S_ENV1;
      S_ENV1: state_next = S_ENV2;
      S_ENV2: state_next = S_EXP;
      S_EXP:  state_next = S_EXPW;
      S_EXPW: state_next = S_Y;
      S_Y:    state_next = S_YW;
      S_YW:   state_next = S_T;
      S_T:    state_next = S_TW;
      S_TW:   state_next = (cnt == 5'd1) ? S_T : S_D;
      S_D:    state_next = S_DW;
      S_DW:   state_next = (cnt == 5'd16) ? S_SH : S_T;
      S_SH:   state_next = S_GM;
      S_GM:   state_next = S_GMW;
      S_GMW:  state_next = S_C0;
      S_C0:   state_next = S_C0W;
      S_C0W:  state_next = S_C1;
      S_C1:   state_next = S_C1W;
      S_C1W:  state_next = S_FIN;
      S_FIN:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and multiplier operands
  always_comb begin
    in_ready  = (state == S_IDLE);
    res_valid = (state == S_FIN);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_SQ: begin
        mul_a = MUL_A_W'(xn);
        mul_b = MUL_B_W'(xn);
      end
      S_LOG: begin
        mul_a = MUL_A_W'(neg_lg);
        mul_b = DB_PER_OCTAVE_Q16;
      end
      S_GC: begin
        mul_a = above ? MUL_A_W'(dv[15:0]) : MUL_A_W'(d2[15:0]);
        mul_b = above ? MUL_B_W'(cfg.slope) : MUL_B_W'(d2[15:0]);
      end
      S_KN2: begin
        mul_a = MUL_A_W'(acc[27:0]);
        mul_b = MUL_B_W'(cfg.slope);
      end
      S_ENV: begin
        mul_a = MUL_A_W'(coef_sel);
        mul_b = env;
      end
      S_ENV1: begin
        mul_a = MUL_A_W'(ONE_Q24 - 25'(coef));
        mul_b = tgt;
      end
      S_EXP: begin
        mul_a = MUL_A_W'(env);
        mul_b = OCTAVE_PER_DB_Q32;
      end
      S_Y: begin
        mul_a = MUL_A_W'(f);
        mul_b = LN2_Q32;
      end
      S_T: begin
        mul_a = term;
        mul_b = y;
      end
      S_D: begin
        mul_a = MUL_A_W'(vdiv);
        mul_b = recip_k(cnt);
      end
      S_GM: begin
        mul_a = gain;
        mul_b = MUL_B_W'(cfg.makeup_gain);
      end
      S_C0: begin
        mul_a = MUL_A_W'(mag0);
        mul_b = gm;
      end
      S_C1: begin
        mul_a = MUL_A_W'(mag1);
        mul_b = gm;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res.out_ch0             = o0;
    res.out_ch1             = o1;
    res.gain_reduction      = gr;
    res.block_max_reduction = eob ? q24_to_q8(run_max) : '0;
    res.block_done          = eob;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      env     <= '0;
      run_max <= '0;
      cnt     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_NORM:  cnt <= '0;
        S_SQW:   cnt <= cnt + 5'd1;
        S_KN3:   cnt <= '0;
        S_DIV:   cnt <= cnt + 5'd1;
        S_YW:    cnt <= 5'd1;
        S_TW:    if (cnt == 5'd1) cnt <= 5'd2;
        S_DW:    cnt <= cnt + 5'd1;
        S_ENV2: begin
          env <= env_new;
          if (env_new > run_max) run_max <= env_new;
        end
        S_FIN: begin
          // Clear the block maximum once the block end is handed over
          if (res_ready && eob) run_max <= '0;
        end
        default: cnt <= cnt;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          s0   <= sample_ch0;
          s1   <= in_s1;
          eob  <= end_of_block;
          mag0 <= in_mag0;
          mag1 <= in_mag1;
          peak <= (in_mag1 > in_mag0) ? in_mag1 : in_mag0;
          o0   <= sample_ch0;
          o1   <= in_s1;
          gr   <= '0;
        end
      end
      S_NORM: begin
        // Normalize the peak to Q1.30; a silent frame reads as the floor
        xdb  <= 16'(-$signed({1'b0, DB_FLOOR_Q8}));
        e    <= 5'(MAG_W - 1) - lz;
        xn   <= nshift[MAG_W+30 -: 31];
        frac <= '0;
      end
      S_SQW: begin
        xn   <= sq_x[31] ? sq_x[31:1] : sq_x[30:0];
        frac <= {frac[14:0], sq_x[31]};
      end
      S_LOGW: xdb <= 16'(-$signed({1'b0, db_mag}));
      S_GC: g <= '0;
      S_GCW: g <= sat15(hi_sum[32:16]);
      S_KN1: acc <= p[55:0];
      S_KN3: begin
        divn <= kn_num[44:19];
        rem  <= '0;
      end
      S_DIV: begin
        rem  <= ge ? 13'(trial - 14'(cfg.knee_width_db)) : trial[12:0];
        divn <= quo;
        if (cnt == 5'(DIVN_W - 1)) g <= (|quo[DIVN_W-1:15]) ? TARGET_MAX_Q8 : quo[14:0];
      end
      S_ENV: coef <= coef_sel;
      S_ENV1: acc <= p[55:0];
      S_ENV2: gr <= q24_to_q8(env_new);
      S_EXPW: begin
        nexp <= p[61:56];
        f    <= p[55:32];
      end
      S_YW: begin
        y    <= p[55:24];
        term <= 33'h1_0000_0000;
        sum  <= 35'h1_0000_0000;
      end
      S_TW: begin
        if (cnt == 5'd1) begin
          term <= 33'(p[63:32]);
          sum  <= sum - 35'(p[63:32]);
        end else begin
          vdiv <= p[63:32];
        end
      end
      S_DW: begin
        term <= 33'(qf);
        sum  <= cnt[0] ? (sum - 35'(qf)) : (sum + 35'(qf));
      end
      S_SH: gain <= (sum[34] || nexp[5]) ? '0 : (sum[32:0] >> nexp[4:0]);
      S_GMW: gm <= (|gm_sum[57:56]) ? 32'hFFFF_FFFF : gm_sum[55:24];
      S_C0W: o0 <= sat_scale(p, s0[SB-1]);
      S_C1W: o1 <= sat_scale(p, s1[SB-1]);
      default: begin
        o0 <= o0;
      end
    endcase
  end

endmodule

>>> design/skc_check.sv
module skc_check (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   cfg_we,
  input logic [2:0]                             cfg_index,
  input logic [23:0]                            cfg_data,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic signed [skc_pkg::SAMPLE_BITS-1:0] sample_ch0,
  input logic signed [skc_pkg::SAMPLE_BITS-1:0] sample_ch1,
  input logic                                   end_of_block,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [skc_pkg::SAMPLE_BITS-1:0] out_ch0,
  input logic signed [skc_pkg::SAMPLE_BITS-1:0] out_ch1,
  input logic [14:0]                            gain_reduction,
  input logic [14:0]                            block_max_reduction,
  input logic                                   block_done
);

  // One transaction in flight: no second accept right after the first
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // A result is never on the output straight after its input is accepted
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after its input");

  // Block maximum only reported at the end of a block
  a_block_max_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !block_done) |-> (block_max_reduction == 15'd0))
    else $error("block maximum reported mid-block");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_ch0) && $stable(out_ch1)))
    else $error("stalled result changed");

endmodule

bind soft_knee_peak_compressor skc_check u_check (.*);

>>> tb/skc_checker.sv
module skc_checker
  import skc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [23:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_ch0,
  input  logic signed [SAMPLE_BITS-1:0] sample_ch1,
  input  logic                          end_of_block,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SAMPLE_BITS-1:0] out_ch0,
  input  logic signed [SAMPLE_BITS-1:0] out_ch1,
  input  logic [14:0]                   gain_reduction,
  input  logic [14:0]                   block_max_reduction,
  input  logic                          block_done,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the register file and the compressor state
  cfg_t              regs;
  longint unsigned   envelope_q24;
  longint unsigned   block_peak_q24;
  res_t              expected_frames[$];

  // Peak magnitude to dBFS in Q7.8, floored at -100 dB
  function automatic longint level_db(longint unsigned pk);
    int              e;
    longint unsigned x, frac, lg, neg, mag;
    if (pk == 0) return -25600;
    e = 0;
    frac = 0;
    while (e < 62 && (pk >> (e + 1)) != 0) e++;
    x = pk << (30 - e);
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        frac = frac | 64'd1;
      end
    end
    lg = (longint'(e) << 16) | frac;
    neg = 64'd23 << 16;
    neg = (neg > lg) ? (neg - lg) : 64'd0;
    mag = (neg * 64'd394566 + (64'd1 << 23)) >> 24;
    if (mag > 64'd25600) mag = 64'd25600;
    return -longint'(mag);
  endfunction

  // Static curve: threshold, slope and soft knee give the target reduction
  function automatic longint unsigned target_q8(longint x);
    logic signed [14:0] thr;
    longint             t, w, lo, hi;
    longint unsigned    s, d, d2, den, g;
    thr = regs.threshold_db;
    t = thr;
    w = longint'(regs.knee_width_db);
    s = regs.slope;
    lo = 2 * t - w;
    hi = 2 * t + w;
    if (2 * x <= lo) return 0;
    if (2 * x > hi) begin
      d = x - t;
      g = (d * s + 64'd32768) >> 16;
    end else begin
      d2 = 2 * x - lo;
      den = 64'd8 * w * 64'd65536;
      if (den == 0) return 0;
      g = (d2 * d2 * s + den / 2) / den;
    end
    return (g > 64'd32767) ? 64'd32767 : g;
  endfunction

  // Linear gain 10^(-env/20) in Q32
  function automatic longint unsigned gain_q32(longint unsigned env);
    longint unsigned e, n, f, y, term;
    longint          sum;
    e = (env * 64'd713378626) >> 32;
    n = e >> 24;
    f = e & 64'hFF_FFFF;
    y = (f * 64'd2977044472) >> 24;
    term = 64'd1 << 32;
    sum = longint'(term);
    for (int k = 1; k <= 16; k++) begin
      term = ((term * y) >> 32) / longint'(k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (n >= 32) return 0;
    return longint'(sum) >> n;
  endfunction

  function automatic logic [14:0] round_q8(longint unsigned v);
    longint unsigned r;
    r = (v + (64'd1 << 15)) >> 16;
    return (r > 64'd32767) ? 15'd32767 : r[14:0];
  endfunction

  // Apply gain to one sample, round half away from zero, saturate
  function automatic logic [SAMPLE_BITS-1:0] scale_sample(longint sv, longint unsigned gm);
    longint unsigned mag;
    mag = (sv < 0) ? longint'(-sv) : longint'(sv);
    mag = (mag * gm + (64'd1 << 23)) >> 24;
    if (sv < 0) begin
      if (mag > 64'd8388608) mag = 64'd8388608;
      return SAMPLE_BITS'(-longint'(mag));
    end
    if (mag > 64'd8388607) mag = 64'd8388607;
    return SAMPLE_BITS'(mag);
  endfunction

  // Work out one output frame and advance the envelope
  function automatic res_t compress_frame(longint s0, longint s1, logic eob);
    res_t            r;
    longint unsigned m0, m1, pk, tgt, a, gm;
    r = '0;
    if (regs.bypass) begin
      r.out_ch0 = s0[SAMPLE_BITS-1:0];
      r.out_ch1 = s1[SAMPLE_BITS-1:0];
    end else begin
      m0 = (s0 < 0) ? longint'(-s0) : longint'(s0);
      m1 = (s1 < 0) ? longint'(-s1) : longint'(s1);
      pk = (m1 > m0) ? m1 : m0;
      tgt = target_q8(level_db(pk)) << 16;
      if (tgt > envelope_q24) a = regs.attack_coef;
      else if (envelope_q24 > tgt + 64'd50331648) a = regs.release_coef;
      else a = regs.slow_release_coef;
      envelope_q24 = (a * envelope_q24 + ((64'd1 << 24) - a) * tgt + (64'd1 << 23)) >> 24;
      if (envelope_q24 > block_peak_q24) block_peak_q24 = envelope_q24;
      r.gain_reduction = round_q8(envelope_q24);
      gm = (gain_q32(envelope_q24) * longint'(regs.makeup_gain) + (64'd1 << 23)) >> 24;
      if (gm > 64'hFFFF_FFFF) gm = 64'hFFFF_FFFF;
      r.out_ch0 = scale_sample(s0, gm);
      r.out_ch1 = scale_sample(s1, gm);
    end
    if (eob) begin
      r.block_max_reduction = round_q8(block_peak_q24);
      r.block_done = 1'b1;
      block_peak_q24 = 0;
    end
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Track registers, predict on input transactions, compare on output ones
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      regs <= '{threshold_db: '0, knee_width_db: '0, slope: '0, makeup_gain: 24'd65536,
                attack_coef: '0, release_coef: '0, slow_release_coef: '0, bypass: 1'b0};
      envelope_q24 = 0;
      block_peak_q24 = 0;
      expected_frames.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_THRESHOLD:    regs.threshold_db <= cfg_data[14:0];
          REG_KNEE_WIDTH:   regs.knee_width_db <= cfg_data[12:0];
          REG_SLOPE:        regs.slope <= cfg_data[15:0];
          REG_MAKEUP:       regs.makeup_gain <= cfg_data;
          REG_ATTACK:       regs.attack_coef <= cfg_data;
          REG_RELEASE:      regs.release_coef <= cfg_data;
          REG_SLOW_RELEASE: regs.slow_release_coef <= cfg_data;
          REG_BYPASS:       regs.bypass <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          errors++;
          $display("%0t unexpected output frame: expected none actual ch0=%0d", $time, out_ch0);
        end else begin
          want = expected_frames.pop_front();
          check_field("out_ch0", signed'(want.out_ch0), out_ch0);
          check_field("out_ch1", signed'(want.out_ch1), out_ch1);
          check_field("gain_reduction", want.gain_reduction, gain_reduction);
          check_field("block_max_reduction", want.block_max_reduction, block_max_reduction);
          check_field("block_done", want.block_done, block_done);
        end
      end
      if (in_valid && in_ready)
        expected_frames.push_back(compress_frame(sample_ch0, sample_ch1, end_of_block));
    end
    pending <= expected_frames.size();
  end

  initial errors = 0;
  initial pending = 0;

endmodule

>>> tb/tb_top.sv
module tb_top;
  import skc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 200;
  localparam int LONG_HOLD   = 400;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [2:0]                    cfg_index;
  logic [23:0]                   cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_ch0;
  logic signed [SAMPLE_BITS-1:0] sample_ch1;
  logic                          end_of_block;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] out_ch0;
  logic signed [SAMPLE_BITS-1:0] out_ch1;
  logic [14:0]                   gain_reduction;
  logic [14:0]                   block_max_reduction;
  logic                          block_done;
  int                            errors;
  int                            pending;
  int                            cycles;
  bit                            no_idle;
  bit                            long_hold_req;

  soft_knee_peak_compressor uut (.*);

  skc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hang guard
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output side: random stalls, one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold_req) begin
        n = LONG_HOLD;
        long_hold_req = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one frame after a random gap; hold it until taken
  task automatic send_frame(logic [23:0] s0, logic [23:0] s1, logic eob);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_ch0 <= s0;
    sample_ch1 <= s1;
    end_of_block <= eob;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected frame has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_all(logic [14:0] thr, logic [12:0] knee, logic [15:0] slp,
                             logic [23:0] mk, logic [23:0] att, logic [23:0] rel,
                             logic [23:0] slow, logic byp);
    drain();
    write_reg(REG_THRESHOLD, 24'(thr));
    write_reg(REG_KNEE_WIDTH, 24'(knee));
    write_reg(REG_SLOPE, 24'(slp));
    write_reg(REG_MAKEUP, mk);
    write_reg(REG_ATTACK, att);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_SLOW_RELEASE, slow);
    write_reg(REG_BYPASS, 24'(byp));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sample with a spread of levels so the detector sweeps the whole dB range
  function automatic logic [23:0] rand_sample();
    logic [23:0] m;
    case ($urandom_range(0, 7))
      0: return 24'($urandom);
      1: return 24'd0;
      2: return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
      default: begin
        m = 24'($urandom) & ((24'd1 << $urandom_range(1, 23)) - 24'd1);
        return $urandom_range(0, 1) ? -m : m;
      end
    endcase
  endfunction

  task automatic random_frames(int count);
    for (int i = 0; i < count; i++)
      send_frame(rand_sample(), rand_sample(), $urandom_range(0, 15) == 0);
  endtask

  function automatic logic [23:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      default: return 24'($urandom_range(0, 24'hFF_FFFF));
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_ch0 = '0;
    sample_ch1 = '0;
    end_of_block = 1'b0;
    no_idle = 0;
    long_hold_req = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: unity gain, no reduction
    send_frame(24'h7F_FFFF, 24'h80_0000, 1'b0);
    send_frame(24'd0, 24'd0, 1'b1);

    // Directed: soft knee, instant attack, extremes of the samples
    program_all(15'(-2560), 13'd1536, 16'd49152, 24'd65536, 24'd0, 24'd0, 24'd0, 1'b0);
    send_frame(24'd0, 24'd0, 1'b0);
    send_frame(24'h7F_FFFF, 24'd0, 1'b0);
    send_frame(24'h80_0000, 24'h7F_FFFF, 1'b0);
    send_frame(24'd1, 24'hFF_FFFF, 1'b1);
    send_frame(24'h0C_0000, 24'hF4_0000, 1'b0);
    send_frame(24'h06_0000, 24'd0, 1'b0);
    send_frame(24'd0, 24'h05_0000, 1'b0);
    send_frame(24'd0, 24'd0, 1'b1);
    // Slow envelope: fast and slow release paths, block max across bypass
    program_all(15'(-4000), 13'd0, 16'd62259, 24'd200000, 24'h80_0000, 24'hE0_0000,
                24'hFF_0000, 1'b0);
    send_frame(24'h7F_FFFF, 24'h7F_FFFF, 1'b0);
    send_frame(24'h7F_FFFF, 24'h80_0000, 1'b0);
    send_frame(24'd0, 24'd0, 1'b0);
    send_frame(24'd100, 24'd0, 1'b0);
    send_frame(24'd0, 24'd0, 1'b0);
    program_all(15'(-4000), 13'd0, 16'd62259, 24'd200000, 24'h80_0000, 24'hE0_0000,
                24'hFF_0000, 1'b1);
    send_frame(24'h12_3456, 24'hED_CBA9, 1'b0);
    send_frame(24'h7F_FFFF, 24'h80_0000, 1'b1);
    // Out-of-range threshold and slope: no reduction, the large makeup gain saturates full scale
    program_all(15'h3FFF, 13'h1FFF, 16'hFFFF, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 1'b0);
    send_frame(24'h7F_FFFF, 24'd5, 1'b0);
    send_frame(24'h80_0000, 24'd0, 1'b1);

    // Random phases over several settings
    program_all(15'(-15360), 13'd6144, 16'd62259, 24'hFF_FFFF, rand_coef(), rand_coef(),
                rand_coef(), 1'b0);
    random_frames(250);
    program_all(15'd0, 13'd0, 16'd0, 24'd0, rand_coef(), rand_coef(), rand_coef(), 1'b0);
    random_frames(150);
    program_all(15'(-1536), 13'd3072, 16'd43690, 24'd131072, 24'hF0_0000, 24'hFF_F000,
                24'hFF_FF00, 1'b0);
    no_idle = 1;
    random_frames(200);
    no_idle = 0;

    // Hold off the output long enough to back up the input
    program_all(15'(-3000), 13'd512, 16'd32768, 24'd65536, 24'd0, 24'd0, 24'd0, 1'b0);
    long_hold_req = 1;
    no_idle = 1;
    random_frames(30);
    no_idle = 0;

    for (int p = 0; p < 5; p++) begin
      program_all(15'(-$urandom_range(0, 15360)), 13'($urandom_range(0, 6144)),
                  16'($urandom_range(0, 62259)), 24'($urandom_range(0, 24'hFF_FFFF)),
                  rand_coef(), rand_coef(), rand_coef(), p == 3);
      random_frames(260);
    end
    program_all(15'($urandom), 13'($urandom), 16'($urandom), 24'($urandom),
                rand_coef(), rand_coef(), rand_coef(), 1'b0);
    random_frames(100);

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
